// ===== sv/sapq_pkg.sv =====
package sapq_pkg;

  // Operation codes carried in the func field
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned TagW  = 32;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 4;

  // Input transaction payload
  typedef struct packed {
    logic             func;
    logic [TagW-1:0]  item_tag;
    logic [PrioW-1:0] item_priority;
  } sapq_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [1:0]       status;
    logic [TagW-1:0]  out_tag;
    logic [PrioW-1:0] out_priority;
    logic [OccW-1:0]  occupancy;
  } sapq_out_t;

  // Controller to datapath command
  typedef struct packed {
    logic exec;  // apply the input transaction and capture its result
  } sapq_cmd_t;

endpackage

// ===== sv/sapq_ctrl.sv =====
module sapq_ctrl
  import sapq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sapq_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // A new transaction may enter when no result waits or the waiting one leaves now
  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign cmd_o.exec  = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state: every executed transaction leaves one result in the output register
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.exec) begin
          state_d     = S_HOLD;
          out_valid_d = 1'b1;
        end
      end
      S_HOLD: begin
        if (cmd_o.exec) begin
          state_d     = S_HOLD;
          out_valid_d = 1'b1;
        end else if (out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/sapq_dpath.sv =====
module sapq_dpath
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sapq_cmd_t cmd_i,
  input  sapq_in_t  in_data_i,
  output sapq_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [TagW-1:0]  tag_q  [DEPTH];
  logic [PrioW-1:0] prio_q [DEPTH];
  logic [TagW-1:0]  tag_d  [DEPTH];
  logic [PrioW-1:0] prio_d [DEPTH];
  logic [CntW-1:0]  count_q, count_d;
  logic [DEPTH-1:0] lower;      // entry is stored and served before the new item
  logic             full, empty, do_write;
  sapq_out_t        res_q, res_d;
  logic [CntW+OccW-1:0] occ_ext;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // Per-entry compare: the set of entries ahead of the new item is a prefix
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lower[i] = (CntW'(i) < count_q) && (prio_q[i] < in_data_i.item_priority);
    end
  end

  // Per-entry next value: keep, take the new item, or shift by one place
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tag_d[i]  = tag_q[i];
      prio_d[i] = prio_q[i];
      if (in_data_i.func == FUNC_INSERT) begin
        if (!lower[i]) begin
          if (i == 0 || lower[(i == 0) ? 0 : i - 1]) begin
            tag_d[i]  = in_data_i.item_tag;
            prio_d[i] = in_data_i.item_priority;
          end else begin
            tag_d[i]  = tag_q[(i == 0) ? 0 : i - 1];
            prio_d[i] = prio_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (i < DEPTH - 1) begin
        tag_d[i]  = tag_q[(i < DEPTH - 1) ? i + 1 : i];
        prio_d[i] = prio_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Count update and result word
  always_comb begin
    count_d             = count_q;
    do_write            = 1'b0;
    res_d.status        = STATUS_DONE;
    res_d.out_tag       = '0;
    res_d.out_priority  = '0;
    if (in_data_i.func == FUNC_INSERT) begin
      if (full) begin
        res_d.status = STATUS_FULL;
      end else begin
        count_d  = count_q + CntW'(1);
        do_write = 1'b1;
      end
    end else begin
      if (empty) begin
        res_d.status = STATUS_EMPTY;
      end else begin
        res_d.out_tag      = tag_q[0];
        res_d.out_priority = prio_q[0];
        count_d            = count_q - CntW'(1);
        do_write           = 1'b1;
      end
    end
    occ_ext         = {{OccW{1'b0}}, count_d};
    res_d.occupancy = occ_ext[OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Entry storage and result register carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
      if (do_write) begin
        for (int i = 0; i < DEPTH; i++) begin
          tag_q[i]  <= tag_d[i];
          prio_q[i] <= prio_d[i];
        end
      end
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== sv/sorted_array_priority_queue.sv =====
// Bounded priority queue of DEPTH entries (tag plus 8-bit priority number, smaller served
// first) held in ascending order across a row of registers. An insert transaction is placed
// ahead of every stored entry with an equal or greater number, using a parallel compare and
// shift across all entries; a remove transaction returns the head and shifts the rest forward.
// Each transaction yields one result with status (done, full, empty) and the occupancy after
// it. A transaction is applied in the cycle it is accepted and its result appears on the next
// cycle; one transaction is accepted per cycle as long as results are taken, since the output
// register is the only stage. No clearing pass is needed after reset.
module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sapq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sapq_out_t out_data_o
);

  sapq_cmd_t cmd;

  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sapq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
